### sv/rf_pulse_width_code_receiver_defines.svh
// ---------------------------------------------------------------------------
// RF pulse-width code receiver assertion macros
// Shared concurrent assertion forms for the receiver checkers.
// ---------------------------------------------------------------------------
`ifndef RF_PULSE_WIDTH_CODE_RECEIVER_DEFINES_SVH
`define RF_PULSE_WIDTH_CODE_RECEIVER_DEFINES_SVH

// Checked only outside reset.
`define RFPW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rfpw assertion failed");

// Checked at every edge, reset included.
`define RFPW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rfpw assertion failed");

`endif

### sv/rfpw_pkg.sv
// ---------------------------------------------------------------------------
// RF pulse-width code receiver package
// Widths, register map, status codes and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfpw_pkg;

  localparam int CODE_BITS = 24;
  localparam int TICK_BITS = 16;
  localparam int BL_W      = $clog2(CODE_BITS + 1);
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [BL_W-1:0] BITS_FULL = BL_W'(CODE_BITS);
  localparam logic [BL_W-1:0] BITS_ONE  = BL_W'(1);

  typedef enum logic [1:0] {
    ST_LEARNED  = 2'd0,
    ST_MATCH    = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  localparam logic [2:0] REG_ARMED    = 3'd0;
  localparam logic [2:0] REG_SYNC_MIN = 3'd1;
  localparam logic [2:0] REG_SYNC_MAX = 3'd2;
  localparam logic [2:0] REG_ZERO_MIN = 3'd3;
  localparam logic [2:0] REG_ZERO_MAX = 3'd4;

  localparam logic [TICK_BITS-1:0] SYNC_MIN_RST = TICK_BITS'(320);
  localparam logic [TICK_BITS-1:0] SYNC_MAX_RST = TICK_BITS'(340);
  localparam logic [TICK_BITS-1:0] ZERO_MIN_RST = TICK_BITS'(20);
  localparam logic [TICK_BITS-1:0] ZERO_MAX_RST = TICK_BITS'(40);

  typedef struct packed {
    logic                 armed;
    logic [TICK_BITS-1:0] sync_min;
    logic [TICK_BITS-1:0] sync_max;
    logic [TICK_BITS-1:0] zero_min;
    logic [TICK_BITS-1:0] zero_max;
  } cfg_t;

endpackage

`default_nettype wire

### sv/rfpw_ifs.sv
// ---------------------------------------------------------------------------
// RF pulse-width code receiver channel interfaces
// Valid/ready channels for measured pulses and for received codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rfpw_pulse_if;
  logic                           valid;
  logic                           ready;
  logic [rfpw_pkg::TICK_BITS-1:0] low_ticks;

  modport source (output valid, output low_ticks, input ready);
  modport sink (input valid, input low_ticks, output ready);
endinterface

interface rfpw_code_if;
  logic                           valid;
  logic                           ready;
  logic [rfpw_pkg::CODE_BITS-1:0] code;
  logic [1:0]                     status;

  modport source (output valid, output code, output status, input ready);
  modport sink (input valid, input code, input status, output ready);
endinterface

`default_nettype wire

### sv/rfpw_cfg_regs.sv
// ---------------------------------------------------------------------------
// RF pulse-width code receiver register file
// APB-style register bank holding the enable bit and the pulse windows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfpw_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rfpw_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rfpw_pkg::DATA_W-1:0]   pwdata,
  output      logic [rfpw_pkg::DATA_W-1:0]   prdata,
  output      logic                          pready,
  output      rfpw_pkg::cfg_t                cfg
);

  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.armed    <= 1'b1;
      cfg.sync_min <= rfpw_pkg::SYNC_MIN_RST;
      cfg.sync_max <= rfpw_pkg::SYNC_MAX_RST;
      cfg.zero_min <= rfpw_pkg::ZERO_MIN_RST;
      cfg.zero_max <= rfpw_pkg::ZERO_MAX_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        rfpw_pkg::REG_ARMED:    cfg.armed    <= pwdata[0];
        rfpw_pkg::REG_SYNC_MIN: cfg.sync_min <= pwdata[rfpw_pkg::TICK_BITS-1:0];
        rfpw_pkg::REG_SYNC_MAX: cfg.sync_max <= pwdata[rfpw_pkg::TICK_BITS-1:0];
        rfpw_pkg::REG_ZERO_MIN: cfg.zero_min <= pwdata[rfpw_pkg::TICK_BITS-1:0];
        rfpw_pkg::REG_ZERO_MAX: cfg.zero_max <= pwdata[rfpw_pkg::TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      rfpw_pkg::REG_ARMED:    prdata[0] = cfg.armed;
      rfpw_pkg::REG_SYNC_MIN: prdata[rfpw_pkg::TICK_BITS-1:0] = cfg.sync_min;
      rfpw_pkg::REG_SYNC_MAX: prdata[rfpw_pkg::TICK_BITS-1:0] = cfg.sync_max;
      rfpw_pkg::REG_ZERO_MIN: prdata[rfpw_pkg::TICK_BITS-1:0] = cfg.zero_min;
      rfpw_pkg::REG_ZERO_MAX: prdata[rfpw_pkg::TICK_BITS-1:0] = cfg.zero_max;
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/rfpw_in_stage.sv
// ---------------------------------------------------------------------------
// RF pulse-width code receiver input stage
// Registers one measured pulse and holds it until the decoder takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfpw_in_stage (
  input  wire logic                            clk,
  input  wire logic                            rst,
  rfpw_pulse_if.sink                           pulse,
  input  wire logic                            take,
  output      logic                            item_valid,
  output      logic [rfpw_pkg::TICK_BITS-1:0]  item_ticks
);

  assign pulse.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (pulse.ready) begin
      item_valid <= pulse.valid;
    end
    if (pulse.valid && pulse.ready) begin
      item_ticks <= pulse.low_ticks;
    end
  end

endmodule

`default_nettype wire

### sv/rfpw_frame_decoder.sv
// ---------------------------------------------------------------------------
// RF pulse-width code receiver frame decoder
// Sync hunt, bit slicing, code shifter, learn/compare and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfpw_frame_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rfpw_pkg::cfg_t                  cfg,
  input  wire logic                            item_valid,
  input  wire logic [rfpw_pkg::TICK_BITS-1:0]  item_ticks,
  output      logic                            take,
  rfpw_code_if.source                          result
);

  logic                             in_frame;
  logic [rfpw_pkg::BL_W-1:0]        bits_left;
  logic [rfpw_pkg::CODE_BITS-1:0]   shifter;
  logic [rfpw_pkg::CODE_BITS-1:0]   learned_code;

  logic                             sync_hit;
  logic                             zero_hit;
  logic                             frame_done;
  logic                             work;
  logic [rfpw_pkg::CODE_BITS-1:0]   shifter_next;
  rfpw_pkg::status_t                status_next;

  assign take = !result.valid || result.ready;
  assign work = take && item_valid && cfg.armed;

  assign sync_hit = (item_ticks >= cfg.sync_min) && (item_ticks <= cfg.sync_max);
  assign zero_hit = (item_ticks >= cfg.zero_min) && (item_ticks <= cfg.zero_max);
  assign shifter_next = {!zero_hit, shifter[rfpw_pkg::CODE_BITS-1:1]};
  assign frame_done = (bits_left <= rfpw_pkg::BITS_ONE) ||
                      (bits_left > rfpw_pkg::BITS_FULL);

  always_comb begin
    if (learned_code == '0) begin
      status_next = rfpw_pkg::ST_LEARNED;
    end else if (shifter_next == learned_code) begin
      status_next = rfpw_pkg::ST_MATCH;
    end else begin
      status_next = rfpw_pkg::ST_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      bits_left    <= rfpw_pkg::BITS_FULL;
      shifter      <= '0;
      learned_code <= '0;
      result.valid <= 1'b0;
    end else begin
      if (work && in_frame && frame_done) begin
        result.valid <= 1'b1;
      end else if (take) begin
        result.valid <= 1'b0;
      end
      if (work) begin
        if (!in_frame) begin
          in_frame <= sync_hit;
        end else if (frame_done) begin
          in_frame      <= 1'b0;
          bits_left     <= rfpw_pkg::BITS_FULL;
          shifter       <= '0;
          result.code   <= shifter_next;
          result.status <= status_next;
          if (learned_code == '0) begin
            learned_code <= shifter_next;
          end
        end else begin
          shifter   <= shifter_next;
          bits_left <= bits_left - rfpw_pkg::BITS_ONE;
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/rf_pulse_width_code_receiver.sv
// ---------------------------------------------------------------------------
// RF pulse-width code receiver
// Decodes 24-bit remote codes from measured low-pulse widths, learns the
// first nonzero code and reports later codes as a match or a mismatch.
// ---------------------------------------------------------------------------
// Channel   Direction  Payload               Handshake
// pulse     in         low_ticks[15:0]       valid/ready
// result    out        code[23:0], status    valid/ready
// apb       in         5 registers, 32 bit   psel/penable, pready high
//
// One pulse is accepted every cycle unless a result stalls; the pulse that
// completes a frame passes the input register, then the result register.
// Reset is synchronous and restores the register defaults and hunt state.
// A stalled result holds the result register, and the input register then
// stops taking pulses; nothing is dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rf_pulse_width_code_receiver (
  input  wire logic                          clk,
  input  wire logic                          rst,
  rfpw_pulse_if.sink                         pulse,
  rfpw_code_if.source                        result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rfpw_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rfpw_pkg::DATA_W-1:0]   pwdata,
  output      logic [rfpw_pkg::DATA_W-1:0]   prdata,
  output      logic                          pready
);

  rfpw_pkg::cfg_t                   cfg;
  logic                             take;
  logic                             item_valid;
  logic [rfpw_pkg::TICK_BITS-1:0]   item_ticks;

  rfpw_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfpw_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .pulse      (pulse),
    .take       (take),
    .item_valid (item_valid),
    .item_ticks (item_ticks)
  );

  rfpw_frame_decoder u_dec (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ticks (item_ticks),
    .take       (take),
    .result     (result)
  );

endmodule

`default_nettype wire

### sv/rfpw_checker.sv
// ---------------------------------------------------------------------------
// RF pulse-width code receiver port checker
// Watches the receiver ports and flags handshake or status slips.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rf_pulse_width_code_receiver_defines.svh"

module rfpw_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           pulse_ready,
  input wire logic                           res_valid,
  input wire logic                           res_ready,
  input wire logic [rfpw_pkg::CODE_BITS-1:0] res_code,
  input wire logic [1:0]                     res_status
);

  `RFPW_ASSERT(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(res_code) && $stable(res_status)))
  `RFPW_ASSERT_ALWAYS(a_reset_quiet, rst |=> !res_valid)
  `RFPW_ASSERT(a_match_nonzero, (res_valid && (res_status == rfpw_pkg::ST_MATCH)) |-> (res_code != '0))
  `RFPW_ASSERT(a_ready_when_empty, !res_valid |-> pulse_ready)

endmodule

bind rf_pulse_width_code_receiver rfpw_checker u_rfpw_checker (
  .clk         (clk),
  .rst         (rst),
  .pulse_ready (pulse.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_code    (result.code),
  .res_status  (result.status)
);

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RF pulse-width code receiver testbench
// Drives measured low-pulse widths into the receiver and checks every code
// transaction against an in-bench decoder with its own copy of the windows,
// the frame state and the learned code. A table of directed pulse runs and
// register writes comes first. Random phases follow, each under a fresh
// register setting and made mostly of well-formed frames mixed with noise.
// Both channels idle and stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int TICK_MAX = (1 << rfpw_pkg::TICK_BITS) - 1;
  localparam int GAP_MAX = 12;
  localparam int SETTLE_CYCLES = 6;
  localparam int LIMIT_NS = 5_000_000;
  localparam int RANDOM_PULSES = 560;
  localparam logic [2:0] REG_UNUSED = 3'd5;

  typedef logic [rfpw_pkg::TICK_BITS-1:0] ticks_t;
  typedef logic [rfpw_pkg::CODE_BITS-1:0] code_t;
  typedef logic [rfpw_pkg::DATA_W-1:0]    data_t;

  typedef struct packed {
    code_t             code;
    rfpw_pkg::status_t status;
  } code_res_t;

  typedef enum logic {ROW_PULSES, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [2:0]        reg_idx;
    ticks_t            value;
    logic [5:0]        count;
    logic              checked;
    code_t             code;
    rfpw_pkg::status_t status;
  } row_t;

  typedef enum int {
    PH_NARROW, PH_SYNC_ALL, PH_TOP_EDGE, PH_NO_ZERO,
    PH_NO_SYNC, PH_DISARMED, PH_WILD, PH_ALL_ZERO
  } phase_kind_e;

  localparam int DIRECTED_ROWS = 29;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd0, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd319, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd341, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd65535, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd320, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd20, 6'd24, 1'b1, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd340, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd41, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd40, 6'd23, 1'b1, 24'h000001, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd330, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd19, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd30, 6'd23, 1'b1, 24'h000001, rfpw_pkg::ST_MATCH},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd330, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd65535, 6'd24, 1'b1, 24'hFFFFFF, rfpw_pkg::ST_MISMATCH},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd330, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd0, 6'd24, 1'b1, 24'hFFFFFF, rfpw_pkg::ST_MISMATCH},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd330, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd30, 6'd10, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_WRITE, rfpw_pkg::REG_ARMED, 16'd0, 6'd0, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd65535, 6'd5, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_WRITE, rfpw_pkg::REG_ARMED, 16'd1, 6'd0, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd21, 6'd14, 1'b1, 24'h000000, rfpw_pkg::ST_MISMATCH},
    '{ROW_WRITE, REG_UNUSED, 16'd0, 6'd0, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd330, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd41, 6'd1, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd40, 6'd23, 1'b1, 24'h000001, rfpw_pkg::ST_MATCH},
    '{ROW_WRITE, rfpw_pkg::REG_SYNC_MIN, 16'd341, 6'd0, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_PULSES, rfpw_pkg::REG_ARMED, 16'd330, 6'd3, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED},
    '{ROW_WRITE, rfpw_pkg::REG_SYNC_MIN, 16'd320, 6'd0, 1'b0, 24'h000000, rfpw_pkg::ST_LEARNED}
  };

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [rfpw_pkg::ADDR_W-1:0]    paddr;
  data_t                          pwdata;
  data_t                          prdata;
  logic                           pready;

  rfpw_pulse_if pulse_ch ();
  rfpw_code_if  code_ch ();

  rfpw_pkg::cfg_t                 cfg_model;
  logic                           in_frame;
  logic [rfpw_pkg::BL_W-1:0]      bits_left;
  code_t                          shifter;
  code_t                          learned_code;

  code_res_t pending_codes[$];
  int        pulses_sent;
  int        pulses_decoded;
  int        codes_predicted;
  int        codes_seen;
  int        mismatches;
  bit        src_steady;
  bit        sink_steady;
  int        sink_hold;

  rf_pulse_width_code_receiver DUT (
    .clk     (clk),
    .rst     (rst),
    .pulse   (pulse_ch),
    .result  (code_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  // Decodes one accepted pulse and queues the code it completes, if any.
  task automatic decode_pulse(input ticks_t ticks, output bit got,
                              output code_res_t res);
    logic zero_bit;
    got = 1'b0;
    res = '0;
    if (!cfg_model.armed) return;
    pulses_decoded++;
    if (!in_frame) begin
      if (ticks >= cfg_model.sync_min && ticks <= cfg_model.sync_max) in_frame = 1'b1;
      return;
    end
    zero_bit = ticks >= cfg_model.zero_min && ticks <= cfg_model.zero_max;
    shifter = {~zero_bit, shifter[rfpw_pkg::CODE_BITS-1:1]};
    if (bits_left <= rfpw_pkg::BITS_ONE || bits_left > rfpw_pkg::BITS_FULL) bits_left = '0;
    else bits_left = bits_left - rfpw_pkg::BITS_ONE;
    if (bits_left != '0) return;
    res.code = shifter;
    in_frame = 1'b0;
    bits_left = rfpw_pkg::BITS_FULL;
    shifter = '0;
    if (learned_code == '0) begin
      learned_code = res.code;
      res.status = rfpw_pkg::ST_LEARNED;
    end else if (res.code == learned_code) begin
      res.status = rfpw_pkg::ST_MATCH;
    end else begin
      res.status = rfpw_pkg::ST_MISMATCH;
    end
    got = 1'b1;
    codes_predicted++;
    pending_codes.push_back(res);
  endtask

  task automatic send_pulse(input ticks_t ticks, output bit got,
                            output code_res_t res);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      pulse_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pulse_ch.valid <= 1'b1;
    pulse_ch.low_ticks <= ticks;
    @(posedge clk);
    while (!pulse_ch.ready) @(posedge clk);
    pulses_sent++;
    decode_pulse(ticks, got, res);
  endtask

  task automatic wait_for_codes();
    pulse_ch.valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  task automatic drain_codes();
    wait_for_codes();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input data_t data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= rfpw_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      rfpw_pkg::REG_ARMED:    cfg_model.armed = data[0];
      rfpw_pkg::REG_SYNC_MIN: cfg_model.sync_min = data[rfpw_pkg::TICK_BITS-1:0];
      rfpw_pkg::REG_SYNC_MAX: cfg_model.sync_max = data[rfpw_pkg::TICK_BITS-1:0];
      rfpw_pkg::REG_ZERO_MIN: cfg_model.zero_min = data[rfpw_pkg::TICK_BITS-1:0];
      rfpw_pkg::REG_ZERO_MAX: cfg_model.zero_max = data[rfpw_pkg::TICK_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic check_regs();
    data_t want;
    data_t got;
    for (int i = rfpw_pkg::REG_ARMED; i <= rfpw_pkg::REG_ZERO_MAX; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= rfpw_pkg::ADDR_W'({3'(i), 2'b00});
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      case (3'(i))
        rfpw_pkg::REG_ARMED:    want = data_t'(cfg_model.armed);
        rfpw_pkg::REG_SYNC_MIN: want = data_t'(cfg_model.sync_min);
        rfpw_pkg::REG_SYNC_MAX: want = data_t'(cfg_model.sync_max);
        rfpw_pkg::REG_ZERO_MIN: want = data_t'(cfg_model.zero_min);
        default:                want = data_t'(cfg_model.zero_max);
      endcase
      if (got !== want) begin
        $display("%0t: register %0d read expected %h actual %h", $time, i, want, got);
        mismatches++;
      end
    end
  endtask

  function automatic ticks_t pick_inside(input int lo, input int hi);
    if (lo > hi) return ticks_t'($urandom);
    case ($urandom_range(0, 3))
      0:       return ticks_t'(lo);
      1:       return ticks_t'(hi);
      default: return ticks_t'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic ticks_t pick_outside(input int lo, input int hi);
    int side;
    if (lo > hi || (lo == 0 && hi == TICK_MAX)) return ticks_t'($urandom);
    if (lo == 0) side = 1;
    else if (hi == TICK_MAX) side = 0;
    else side = $urandom_range(0, 1);
    if (side == 0) return ticks_t'($urandom_range(0, 1) ? lo - 1 : $urandom_range(0, lo - 1));
    return ticks_t'($urandom_range(0, 1) ? hi + 1 : $urandom_range(hi + 1, TICK_MAX));
  endfunction

  task automatic configure_phase(input phase_kind_e kind);
    int sm;
    int sx;
    int zm;
    int zx;
    sm = $urandom_range(50, 65000);
    sx = sm + $urandom_range(0, 300);
    zm = $urandom_range(0, 2000);
    zx = zm + $urandom_range(0, 400);
    case (kind)
      PH_SYNC_ALL: begin
        sm = 0; sx = TICK_MAX; zm = 0; zx = 0;
      end
      PH_TOP_EDGE: begin
        sm = TICK_MAX; sx = TICK_MAX; zm = TICK_MAX; zx = TICK_MAX;
      end
      PH_NO_ZERO: begin
        zm = TICK_MAX; zx = 0;
      end
      PH_NO_SYNC: begin
        sm = $urandom_range(1, TICK_MAX);
        sx = $urandom_range(0, sm - 1);
      end
      PH_WILD: begin
        sm = $urandom_range(0, TICK_MAX); sx = $urandom_range(0, TICK_MAX);
        zm = $urandom_range(0, TICK_MAX); zx = $urandom_range(0, TICK_MAX);
      end
      PH_ALL_ZERO: begin
        sm = 0; sx = 0; zm = 0; zx = TICK_MAX;
      end
      default: ;
    endcase
    reg_write(rfpw_pkg::REG_ARMED, {31'($urandom), kind != PH_DISARMED});
    reg_write(rfpw_pkg::REG_SYNC_MIN, {16'($urandom), 16'(sm)});
    reg_write(rfpw_pkg::REG_SYNC_MAX, {16'($urandom), 16'(sx)});
    reg_write(rfpw_pkg::REG_ZERO_MIN, {16'($urandom), 16'(zm)});
    reg_write(rfpw_pkg::REG_ZERO_MAX, {16'($urandom), 16'(zx)});
  endtask

  // A sync pulse and 24 bits. The word is often the learned code or a near miss.
  task automatic send_frame();
    code_t     word;
    int        pick;
    bit        got;
    code_res_t res;
    pick = $urandom_range(0, 9);
    if (pick < 4) word = learned_code;
    else if (pick < 6)
      word = learned_code ^ (code_t'(1) << $urandom_range(0, rfpw_pkg::CODE_BITS - 1));
    else if (pick == 6) word = $urandom_range(0, 1) ? '0 : '1;
    else word = code_t'($urandom);
    send_pulse(pick_inside(cfg_model.sync_min, cfg_model.sync_max), got, res);
    for (int i = 0; i < rfpw_pkg::CODE_BITS; i++) begin
      if (word[i]) send_pulse(pick_outside(cfg_model.zero_min, cfg_model.zero_max), got, res);
      else send_pulse(pick_inside(cfg_model.zero_min, cfg_model.zero_max), got, res);
    end
  endtask

  task automatic send_noise();
    ticks_t    ticks;
    bit        got;
    code_res_t res;
    repeat ($urandom_range(1, 30)) begin
      case ($urandom_range(0, 2))
        0:       ticks = ticks_t'($urandom);
        1:       ticks = pick_inside(cfg_model.sync_min, cfg_model.sync_max);
        default: ticks = pick_outside(cfg_model.zero_min, cfg_model.zero_max);
      endcase
      send_pulse(ticks, got, res);
    end
  endtask

  always @(posedge clk) begin : code_sink
    int        hold_n;
    code_res_t want;
    if (rst) begin
      code_ch.ready <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (code_ch.valid && code_ch.ready) begin
        if (pending_codes.size() == 0) begin
          $display("%0t: code %h status %0d arrived with none expected", $time,
                   code_ch.code, code_ch.status);
          mismatches++;
        end else begin
          want = pending_codes.pop_front();
          codes_seen++;
          if (code_ch.code !== want.code) begin
            $display("%0t: code expected %h actual %h", $time, want.code, code_ch.code);
            mismatches++;
          end
          if (code_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     code_ch.status);
            mismatches++;
          end
        end
        hold_n = sink_steady ? 0 : $urandom_range(0, GAP_MAX);
        sink_hold <= hold_n;
        code_ch.ready <= (hold_n == 0);
      end else if (sink_hold != 0) begin
        sink_hold <= sink_hold - 1;
        code_ch.ready <= (sink_hold == 1);
      end else begin
        code_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    row_t        row;
    bit          got;
    code_res_t   res;
    int          phase;
    phase_kind_e kind;
    int          phase_end;
    int          pulse_base;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pulse_ch.valid = 1'b0;
    pulse_ch.low_ticks = '0;
    cfg_model = '{1'b1, rfpw_pkg::SYNC_MIN_RST, rfpw_pkg::SYNC_MAX_RST,
                  rfpw_pkg::ZERO_MIN_RST, rfpw_pkg::ZERO_MAX_RST};
    in_frame = 1'b0;
    bits_left = rfpw_pkg::BITS_FULL;
    shifter = '0;
    learned_code = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_regs();

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      got = 1'b0;
      if (row.kind == ROW_WRITE) begin
        drain_codes();
        reg_write(row.reg_idx, data_t'(row.value));
      end else begin
        for (int k = 0; k < row.count; k++) send_pulse(row.value, got, res);
      end
      if (row.checked && (!got || res.code != row.code || res.status != row.status)) begin
        $display("%0t: table row %0d expected %h/%0d actual %h/%0d (code made %0b)",
                 $time, i, row.code, row.status, res.code, res.status, got);
        mismatches++;
      end
    end

    phase = 0;
    pulse_base = pulses_sent;
    while (pulses_sent - pulse_base < RANDOM_PULSES) begin
      if (phase <= PH_ALL_ZERO) kind = phase_kind_e'(phase);
      else kind = $urandom_range(0, 1) ? PH_NARROW : PH_WILD;
      drain_codes();
      src_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      configure_phase(kind);
      check_regs();
      phase_end = pulses_sent + $urandom_range(80, 160);
      while (pulses_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_frame();
        if ($urandom_range(0, 15) == 0) wait_for_codes();
      end
      phase++;
    end

    drain_codes();
    $display("Sent %0d pulses (%0d while armed) and checked %0d codes", pulses_sent,
             pulses_decoded, codes_seen);
    $display("over the reset setting, %0d random register settings and all table rows",
             phase);
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/rfpw_pkg.sv
sv/rfpw_ifs.sv
sv/rfpw_cfg_regs.sv
sv/rfpw_in_stage.sv
sv/rfpw_frame_decoder.sv
sv/rf_pulse_width_code_receiver.sv
sv/rfpw_checker.sv
sim/tb_top.sv
